@@ rtl/hfa_pkg.sv @@
package hfa_pkg;

    localparam int FRAC_W = 10;
    localparam int EXP_W = 5;
    localparam int WORD_W = 16;
    localparam int ALIGN_MAX = 13;
    localparam int SUM_W = FRAC_W + 1 + ALIGN_MAX + 1;

    localparam logic [WORD_W-1:0] NAN_WORD = 16'h7C01;
    localparam logic [EXP_W-1:0] EXP_INF = 5'd31;

    typedef logic [WORD_W-1:0] word_t;

endpackage

@@ rtl/half_float_adder.sv @@
// binary16 adder without subnormals: a word with exponent 0 is zero, any NaN
// gives 0x7C01, opposite infinities give 0x7C01, overflow saturates to infinity
// and underflow or exact cancellation flushes to zero. Each beat carries a_word in
// bits 15:0 and b_word in bits 31:16; the sum comes back one beat per operand beat.
// Throughput is one beat per cycle while m_tready does not stall the output; a beat passes
// through the operand register and then the result register, with the align, add,
// normalize and round logic in between.
module half_float_adder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // a_word, b_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // sum_word
);

    localparam int SW = hfa_pkg::SUM_W;
    localparam int FW = hfa_pkg::FRAC_W;
    localparam int PW = $clog2(SW);

    hfa_pkg::word_t a_reg, b_reg, sum_reg, sum_next;
    logic           in_valid_reg, out_valid_reg;
    logic           advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            a_reg <= s_tdata[15:0];
            b_reg <= s_tdata[31:16];
        end
        if (advance && in_valid_reg) begin
            sum_reg <= sum_next;
        end
    end

    logic       sa, sb, sx, sy;
    logic [4:0] ea, eb, ex, ey, d;
    logic [9:0] fa, fb, fx, fy;
    logic       nan_a, nan_b, inf_a, inf_b, a_big;
    logic [3:0] dc;
    logic [SW-1:0] mx, my, s, n;
    logic [PW-1:0] p;
    logic [11:0] m;
    logic signed [7:0] e;

    always_comb begin
        sa = a_reg[15];
        sb = b_reg[15];
        ea = a_reg[14:10];
        eb = b_reg[14:10];
        fa = a_reg[9:0];
        fb = b_reg[9:0];
        nan_a = (ea == hfa_pkg::EXP_INF) && (fa != '0);
        nan_b = (eb == hfa_pkg::EXP_INF) && (fb != '0);
        inf_a = (ea == hfa_pkg::EXP_INF) && (fa == '0);
        inf_b = (eb == hfa_pkg::EXP_INF) && (fb == '0);
        a_big = a_reg[14:0] >= b_reg[14:0];
        sx = a_big ? sa : sb;
        ex = a_big ? ea : eb;
        fx = a_big ? fa : fb;
        sy = a_big ? sb : sa;
        ey = a_big ? eb : ea;
        fy = a_big ? fb : fa;
        d  = ex - ey;
        // far operand only matters as a sticky one below the round bit
        if (d > 5'(hfa_pkg::ALIGN_MAX)) begin
            dc = 4'(hfa_pkg::ALIGN_MAX);
            my = SW'(1);
        end else begin
            dc = d[3:0];
            my = SW'({1'b1, fy});
        end
        mx = SW'({1'b1, fx}) << dc;
        s  = (sx == sy) ? mx + my : mx - my;
        p  = '0;
        for (int i = 0; i < SW; i++) begin
            if (s[i]) begin
                p = PW'(i);
            end
        end
        n = s << (PW'(SW - 1) - p);
        m = {1'b0, n[SW-1 -: FW+1]} + 12'(n[SW-FW-2]);
        e = 8'(ex) - 8'(dc) + 8'(p) - 8'(FW);
        if (m[11]) begin
            m = m >> 1;
            e = e + 8'sd1;
        end

        if (nan_a || nan_b) begin
            sum_next = hfa_pkg::NAN_WORD;
        end else if (inf_a && inf_b) begin
            sum_next = (sa == sb) ? {sa, hfa_pkg::EXP_INF, 10'd0} : hfa_pkg::NAN_WORD;
        end else if (inf_a) begin
            sum_next = {sa, hfa_pkg::EXP_INF, 10'd0};
        end else if (inf_b) begin
            sum_next = {sb, hfa_pkg::EXP_INF, 10'd0};
        end else if (ea == '0 && eb == '0) begin
            sum_next = '0;
        end else if (ea == '0) begin
            sum_next = b_reg;
        end else if (eb == '0) begin
            sum_next = a_reg;
        end else if (s == '0) begin
            sum_next = '0;
        end else if (e >= 8'sd31) begin
            sum_next = {sx, hfa_pkg::EXP_INF, 10'd0};
        end else if (e <= 8'sd0) begin
            sum_next = {sx, 15'd0};
        end else begin
            sum_next = {sx, e[4:0], m[9:0]};
        end
    end

endmodule
